// ===== rtl/core/csa1_pkg.sv =====
// Shared constants, types and helper functions of the CSA #1 channel hopper.
`default_nettype none

package csa1_pkg;

   // Number of data channels that the hopper walks.
   localparam int NUM_DATA_CHANNELS = 37;
   // Channel map width; channels at or above it count as unused.
   localparam int MAP_BITS = 37;

   localparam int CH_W = (NUM_DATA_CHANNELS > 1) ? $clog2(NUM_DATA_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_DATA_CHANNELS + 1);
   localparam int HOP_W = 5;
   localparam int SUM_W = ((CH_W > HOP_W) ? CH_W : HOP_W) + 1;
   localparam int DIV_IDX_W = (CH_W > 1) ? $clog2(CH_W) : 1;
   localparam int CTR_W = 16;
   localparam int OPCODE_W = 2;
   localparam int OUT_CH_W = 6;
   localparam int RF_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = MAP_BITS;

   localparam logic [CTR_W-1:0] HALF_RANGE = 16'h8000;
   localparam logic [HOP_W-1:0] HOP_RESET = 5'd5;
   localparam logic [RF_W-1:0] RF_LOW_MAX = 7'd10;
   localparam logic [RF_W-1:0] RF_BASE_LOW = 7'd4;
   localparam logic [RF_W-1:0] RF_BASE_HIGH = 7'd6;

   typedef logic [MAP_BITS-1:0] map_type;
   typedef logic [CH_W-1:0] chan_idx_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [CTR_W-1:0] counter_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START  = 2'd0,
      OP_EVENT  = 2'd1,
      OP_UPDATE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOP_INCREMENT = 1'd0,
      CSR_INITIAL_MAP   = 1'd1
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic update;
      logic event_begin;
      logic walk_step;
      logic hop_load;
      logic reduce;
      logic pick_direct;
      logic div_init;
      logic div_step;
      logic pick_table;
      logic out_load;
   } csa1_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pend_due;
      logic walk_last;
      logic sum_ok;
      logic use_direct;
      logic div_last;
      logic out_free;
   } csa1_status_type;

   // True when channel c is marked used in the map.
   function automatic logic chan_used(map_type m, chan_idx_type c);
      map_type sh;
      begin
         sh = m >> c;
         return sh[0] && (32'(c) < MAP_BITS);
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csa1_if.sv =====
// Request and response channel interfaces of the CSA #1 channel hopper.
`default_nettype none

interface csa1_req_if;
   logic valid;
   logic ready;
   logic [csa1_pkg::OPCODE_W-1:0] opcode;
   logic [csa1_pkg::MAP_BITS-1:0] new_map;
   logic [csa1_pkg::CTR_W-1:0] instant;

   modport source(output valid, output opcode, output new_map, output instant, input ready);
   modport sink(input valid, input opcode, input new_map, input instant, output ready);
endinterface

interface csa1_rsp_if;
   logic valid;
   logic ready;
   logic [csa1_pkg::OUT_CH_W-1:0] channel;
   logic [csa1_pkg::RF_W-1:0] rf_offset_mhz;
   logic [csa1_pkg::CTR_W-1:0] event_counter;
   logic map_switched;

   modport source(output valid, output channel, output rf_offset_mhz, output event_counter,
                  output map_switched, input ready);
   modport sink(input valid, input channel, input rf_offset_mhz, input event_counter,
                input map_switched, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/csa1_ctrl.sv =====
// Controller state machine of the CSA #1 channel hopper.
`default_nettype none

module csa1_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [csa1_pkg::OPCODE_W-1:0]    req_opcode,
   output logic                             req_ready,
   input  csa1_pkg::csa1_status_type        status,
   output csa1_pkg::csa1_cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_HOP,
      ST_REDUCE,
      ST_SELECT,
      ST_DIV,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic walk_event_ff, walk_event_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      walk_event_in = walk_event_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  csa1_pkg::OP_START: begin
                     cmd.start = 1'b1;
                     walk_event_in = 1'b0;
                     state_in = ST_WALK;
                  end
                  csa1_pkg::OP_UPDATE: begin
                     cmd.update = 1'b1;
                  end
                  csa1_pkg::OP_EVENT: begin
                     cmd.event_begin = 1'b1;
                     walk_event_in = 1'b1;
                     state_in = status.pend_due ? ST_WALK : ST_HOP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = walk_event_ff ? ST_HOP : ST_IDLE;
            end
         end
         ST_HOP: begin
            cmd.hop_load = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.sum_ok) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (status.use_direct) begin
               cmd.pick_direct = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.pick_table = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_event_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         walk_event_ff <= walk_event_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/csa1_dp.sv =====
// Datapath of the CSA #1 channel hopper: state, used-channel table, divider, result register.
`default_nettype none

module csa1_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  csa1_pkg::csa1_cmd_type              cmd,
   output csa1_pkg::csa1_status_type           status,
   input  logic                                csr_write_enable,
   input  logic [csa1_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csa1_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic [csa1_pkg::MAP_BITS-1:0]       req_new_map,
   input  logic [csa1_pkg::CTR_W-1:0]          req_instant,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [csa1_pkg::OUT_CH_W-1:0]       rsp_channel,
   output logic [csa1_pkg::RF_W-1:0]           rsp_rf_offset_mhz,
   output logic [csa1_pkg::CTR_W-1:0]          rsp_event_counter,
   output logic                                rsp_map_switched
);

   // Configuration registers.
   logic [csa1_pkg::HOP_W-1:0] hop_ff;
   csa1_pkg::map_type init_map_ff;

   // Connection state.
   csa1_pkg::chan_idx_type last_unm_ff;
   csa1_pkg::counter_type event_count_ff;
   csa1_pkg::map_type active_map_ff;
   csa1_pkg::count_type used_total_ff;
   logic pending_ff;
   csa1_pkg::map_type pending_map_ff;
   csa1_pkg::counter_type pending_instant_ff;

   // Table build.
   csa1_pkg::chan_idx_type used_table [csa1_pkg::NUM_DATA_CHANNELS];
   csa1_pkg::map_type walk_map_ff;
   csa1_pkg::chan_idx_type walk_idx_ff;
   csa1_pkg::count_type build_ff;
   logic walk_start_ff;
   logic sw_ff;

   // Hop, remainder and table read.
   logic [csa1_pkg::SUM_W-1:0] sum_ff;
   csa1_pkg::count_type rem_ff;
   logic [csa1_pkg::DIV_IDX_W-1:0] div_idx_ff;
   csa1_pkg::chan_idx_type rd_ff;
   logic from_table_ff;

   // Result register.
   logic out_valid_ff;
   logic [csa1_pkg::OUT_CH_W-1:0] out_ch_ff;
   logic [csa1_pkg::RF_W-1:0] out_rf_ff;
   csa1_pkg::counter_type out_ctr_ff;
   logic out_sw_ff;

   logic walk_bit;
   logic walk_last;
   csa1_pkg::count_type new_total;
   logic pend_due;
   csa1_pkg::counter_type ctr_diff;
   logic sum_ok;
   logic [csa1_pkg::CNT_W:0] shifted;
   logic [csa1_pkg::CNT_W:0] divisor;
   csa1_pkg::chan_idx_type ch_sel;
   logic [csa1_pkg::RF_W-1:0] ch_wide;
   logic [csa1_pkg::RF_W-1:0] rf_calc;

   assign walk_bit = csa1_pkg::chan_used(walk_map_ff, walk_idx_ff);
   assign walk_last = (walk_idx_ff == csa1_pkg::CH_W'(csa1_pkg::NUM_DATA_CHANNELS - 1));
   assign new_total = build_ff + csa1_pkg::CNT_W'(walk_bit);

   // The instant is reached when counter minus instant lies in the lower half of the range.
   assign ctr_diff = event_count_ff - pending_instant_ff;
   assign pend_due = pending_ff && (ctr_diff < csa1_pkg::HALF_RANGE);

   assign sum_ok = (sum_ff < csa1_pkg::SUM_W'(csa1_pkg::NUM_DATA_CHANNELS));

   assign shifted = {rem_ff, last_unm_ff[div_idx_ff]};
   assign divisor = {1'b0, used_total_ff};

   assign ch_sel = from_table_ff ? rd_ff : last_unm_ff;
   assign ch_wide = csa1_pkg::RF_W'(ch_sel);
   assign rf_calc = (ch_wide <= csa1_pkg::RF_LOW_MAX) ?
                    ((ch_wide << 1) + csa1_pkg::RF_BASE_LOW) :
                    ((ch_wide << 1) + csa1_pkg::RF_BASE_HIGH);

   always_comb begin
      status.pend_due = pend_due;
      status.walk_last = walk_last;
      status.sum_ok = sum_ok;
      status.use_direct = csa1_pkg::chan_used(active_map_ff, last_unm_ff) ||
                          (used_total_ff == '0);
      status.div_last = (div_idx_ff == '0);
      status.out_free = !out_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff <= csa1_pkg::HOP_RESET;
         init_map_ff <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            csa1_pkg::CSR_HOP_INCREMENT: hop_ff <= csr_write_data[csa1_pkg::HOP_W-1:0];
            csa1_pkg::CSR_INITIAL_MAP: init_map_ff <= csr_write_data[csa1_pkg::MAP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_unm_ff <= '0;
         event_count_ff <= '0;
         active_map_ff <= '0;
         used_total_ff <= '0;
         pending_ff <= 1'b0;
         pending_map_ff <= '0;
         pending_instant_ff <= '0;
         sw_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            last_unm_ff <= '0;
            event_count_ff <= '0;
            pending_ff <= 1'b0;
         end
         if (cmd.update) begin
            pending_map_ff <= req_new_map;
            pending_instant_ff <= req_instant;
            pending_ff <= 1'b1;
         end
         if (cmd.event_begin) begin
            sw_ff <= 1'b0;
            if (pend_due) begin
               pending_ff <= 1'b0;
            end
         end
         // An empty new map leaves the old map and table in place.
         if (cmd.walk_step && walk_last && (walk_start_ff || new_total != '0)) begin
            active_map_ff <= walk_map_ff;
            used_total_ff <= new_total;
            if (!walk_start_ff) begin
               sw_ff <= 1'b1;
            end
         end
         if (cmd.reduce && sum_ok) begin
            last_unm_ff <= sum_ff[csa1_pkg::CH_W-1:0];
         end
         if (cmd.out_load) begin
            event_count_ff <= event_count_ff + 1'b1;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Walk, hop, divider and result payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start || (cmd.event_begin && pend_due)) begin
         walk_map_ff <= cmd.start ? init_map_ff : pending_map_ff;
         walk_start_ff <= cmd.start;
         walk_idx_ff <= '0;
         build_ff <= '0;
      end else if (cmd.walk_step) begin
         walk_idx_ff <= walk_idx_ff + 1'b1;
         build_ff <= new_total;
      end
      if (cmd.hop_load) begin
         sum_ff <= csa1_pkg::SUM_W'(last_unm_ff) + csa1_pkg::SUM_W'(hop_ff);
      end else if (cmd.reduce && !sum_ok) begin
         sum_ff <= sum_ff - csa1_pkg::SUM_W'(csa1_pkg::NUM_DATA_CHANNELS);
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         div_idx_ff <= csa1_pkg::DIV_IDX_W'(csa1_pkg::CH_W - 1);
      end else if (cmd.div_step) begin
         if (shifted >= divisor) begin
            rem_ff <= csa1_pkg::CNT_W'(shifted - divisor);
         end else begin
            rem_ff <= shifted[csa1_pkg::CNT_W-1:0];
         end
         div_idx_ff <= div_idx_ff - 1'b1;
      end
      if (cmd.pick_direct) begin
         from_table_ff <= 1'b0;
      end else if (cmd.pick_table) begin
         from_table_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_ch_ff <= csa1_pkg::OUT_CH_W'(ch_sel);
         out_rf_ff <= rf_calc;
         out_ctr_ff <= event_count_ff;
         out_sw_ff <= sw_ff;
      end
   end

   // Used-channel table: one write port during the walk, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.walk_step && walk_bit) begin
         used_table[build_ff[csa1_pkg::CH_W-1:0]] <= walk_idx_ff;
      end
      rd_ff <= used_table[rem_ff[csa1_pkg::CH_W-1:0]];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_channel = out_ch_ff;
   assign rsp_rf_offset_mhz = out_rf_ff;
   assign rsp_event_counter = out_ctr_ff;
   assign rsp_map_switched = out_sw_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ble_csa1_channel_hopper.sv =====
// Top level of the BLE Channel Selection Algorithm #1 data channel hopper.
`default_nettype none

// This block picks the data channel of each connection event of one link with Channel
// Selection Algorithm #1. A request transfer with opcode start loads the initial channel
// map register, rebuilds the table of used channels by walking all 37 channels once, and
// clears the unmapped channel, the event counter and any pending map update; it returns
// no response. A map-update transfer stores a new map and its instant and returns no
// response. An event transfer first adopts a pending map whose instant has been reached,
// which costs one more table walk (a map without channels is dropped and the old one
// stays), then steps the unmapped channel by the hop increment, and remaps an unused
// channel through a six-step serial remainder unit followed by a registered read of the
// used-channel table. The block handles one request at a time; the response sits in an
// output register, so the next request is taken while a response waits, and a later
// event holds in its last step until that response transfer has happened. Configuration
// writes (index 0 hop increment, index 1 initial map) must be made by the user only while
// the block is idle; the block itself does not enforce this.
module ble_csa1_channel_hopper (
   input  logic                              clock,
   input  logic                              reset,
   csa1_req_if.sink                          req_bus,
   csa1_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [csa1_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csa1_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   csa1_pkg::csa1_cmd_type cmd;
   csa1_pkg::csa1_status_type status;
   logic req_ready;
   logic rsp_valid;
   logic [csa1_pkg::OUT_CH_W-1:0] rsp_channel;
   logic [csa1_pkg::RF_W-1:0] rsp_rf_offset_mhz;
   logic [csa1_pkg::CTR_W-1:0] rsp_event_counter;
   logic rsp_map_switched;

   // The controller sequences each request and raises ready only while idle.
   csa1_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds configuration, connection state, the table and the response register.
   csa1_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_new_map       (req_bus.new_map),
      .req_instant       (req_bus.instant),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_valid),
      .rsp_channel       (rsp_channel),
      .rsp_rf_offset_mhz (rsp_rf_offset_mhz),
      .rsp_event_counter (rsp_event_counter),
      .rsp_map_switched  (rsp_map_switched)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign rsp_bus.channel = rsp_channel;
   assign rsp_bus.rf_offset_mhz = rsp_rf_offset_mhz;
   assign rsp_bus.event_counter = rsp_event_counter;
   assign rsp_bus.map_switched = rsp_map_switched;

endmodule

`default_nettype wire

// ===== test/ble_csa1_channel_hopper_test.sv =====
// Self-checking testbench of the CSA #1 channel hopper, with a built-in channel predictor.
`timescale 1ns / 100ps

module ble_csa1_channel_hopper_test;

   // Opcode 3 has no meaning; the hopper must drop such transfers without a trace.
   localparam logic [csa1_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

   // Cycles to wait once the last response has arrived. A start transfer returns
   // nothing and still walks the map, so this covers the slowest request in flight.
   localparam int DRAIN_CYCLES = 64;

   // Cycles without any transfer or register write before the run is declared hung.
   // The longest quiet stretch in a correct run is the drain pause plus a slow event.
   localparam int WATCHDOG_LIMIT = 2000;

   localparam int RANDOM_PHASES = 12;
   localparam int ITEMS_PER_PHASE = 87;

   typedef struct {
      logic [csa1_pkg::OPCODE_W-1:0] op;
      csa1_pkg::map_type             new_map;
      csa1_pkg::counter_type         instant;
   } hop_req_type;

   typedef struct {
      logic [csa1_pkg::OUT_CH_W-1:0] channel;
      logic [csa1_pkg::RF_W-1:0]     rf_offset;
      csa1_pkg::counter_type         counter;
      logic                          switched;
   } hop_result_type;

   logic clock;
   logic reset;
   logic                            csr_write_enable;
   logic [csa1_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [csa1_pkg::CSR_DATA_W-1:0] csr_write_data;

   csa1_req_if req_bus();
   csa1_rsp_if rsp_bus();

   ble_csa1_channel_hopper dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Requests waiting to be driven, and the channel reports that accepted events owe.
   hop_req_type    pending_reqs[$];
   hop_result_type channels_due[$];

   // Predictor copy of the register file.
   logic [csa1_pkg::HOP_W-1:0] cfg_hop;
   csa1_pkg::map_type          cfg_map;

   // Predictor copy of the connection state.
   int                     unmapped;
   csa1_pkg::counter_type  evt_count;
   csa1_pkg::map_type      active_map;
   csa1_pkg::chan_idx_type used_tab[csa1_pkg::NUM_DATA_CHANNELS];
   int                     used_cnt;
   logic                   upd_pending;
   csa1_pkg::map_type      pend_map;
   csa1_pkg::counter_type  pend_inst;

   // Event counter as the stimulus generator expects it when the queued items run,
   // so that map update instants can be placed right around the live counter.
   csa1_pkg::counter_type gen_count;
   int                    reqs_made;

   int mismatches;
   int idle_cycles;
   bit req_take, rsp_take;
   bit req_fire, rsp_fire;
   int req_gap, req_calm;
   int rsp_stall, rsp_calm;
   hop_req_type    nxt;
   hop_result_type want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Rebuild the table of used channels from a map, lowest channel first.
   function automatic void load_used(input csa1_pkg::map_type m);
      active_map = m;
      used_cnt = 0;
      for (int c = 0; c < csa1_pkg::NUM_DATA_CHANNELS; c++) begin
         if (c < csa1_pkg::MAP_BITS && m[c]) begin
            used_tab[used_cnt] = csa1_pkg::chan_idx_type'(c);
            used_cnt++;
         end
      end
   endfunction

   // Apply one accepted request to the predicted state. An event also queues the
   // channel report that the hopper has to produce for it.
   function automatic void step_hopper(input logic [csa1_pkg::OPCODE_W-1:0] op,
                                       input csa1_pkg::map_type nmap,
                                       input csa1_pkg::counter_type inst);
      hop_result_type r;
      csa1_pkg::counter_type age;
      int ch;
      int rf;
      case (op)
         csa1_pkg::OP_START: begin
            load_used(cfg_map);
            unmapped = 0;
            evt_count = '0;
            upd_pending = 1'b0;
         end
         csa1_pkg::OP_UPDATE: begin
            // A later update simply overwrites an earlier one still waiting.
            pend_map = nmap;
            pend_inst = inst;
            upd_pending = 1'b1;
         end
         csa1_pkg::OP_EVENT: begin
            r.switched = 1'b0;
            // The instant counts as reached when counter minus instant, taken on
            // 16 bits, lands in the lower half of the range.
            age = evt_count - pend_inst;
            if (upd_pending && !age[csa1_pkg::CTR_W-1]) begin
               // A map without any channel is thrown away and the old map stays.
               if (pend_map != '0) begin
                  load_used(pend_map);
                  r.switched = 1'b1;
               end
               upd_pending = 1'b0;
            end
            unmapped = (unmapped + int'(cfg_hop)) % csa1_pkg::NUM_DATA_CHANNELS;
            // A used channel is taken as is; so is any channel when the map is empty.
            if ((unmapped < csa1_pkg::MAP_BITS && active_map[unmapped]) || used_cnt == 0) begin
               ch = unmapped;
            end else begin
               ch = int'(used_tab[unmapped % used_cnt]);
            end
            // Channels 0 to 10 sit below the advertising channel at 2426 MHz.
            rf = (ch <= 10) ? 2 * ch + 4 : 2 * ch + 6;
            r.channel = csa1_pkg::OUT_CH_W'(ch);
            r.rf_offset = csa1_pkg::RF_W'(rf);
            r.counter = evt_count;
            channels_due.push_back(r);
            evt_count = evt_count + 16'd1;
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Idle cycles before the next transfer on one side: mostly a random draw, with
   // occasional runs of back-to-back transfers.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   // A channel map from a mix of shapes: full, empty, one channel, sparse, dense, any.
   function automatic csa1_pkg::map_type rand_map();
      logic [63:0] bits_a;
      logic [63:0] bits_b;
      csa1_pkg::map_type m;
      bits_a = {$urandom, $urandom};
      bits_b = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: m = '1;
         1: m = '0;
         2: begin
            m = '0;
            m[$urandom_range(0, csa1_pkg::MAP_BITS - 1)] = 1'b1;
         end
         3: m = bits_a[csa1_pkg::MAP_BITS-1:0] & bits_b[csa1_pkg::MAP_BITS-1:0] &
                bits_a[csa1_pkg::MAP_BITS+2:3];
         4: m = bits_a[csa1_pkg::MAP_BITS-1:0] | bits_b[csa1_pkg::MAP_BITS-1:0];
         default: m = bits_a[csa1_pkg::MAP_BITS-1:0];
      endcase
      return m;
   endfunction

   // An update instant: mostly a few events around the current counter, sometimes
   // at the edges of the wrap-safe window, sometimes anywhere.
   function automatic csa1_pkg::counter_type pick_instant();
      case ($urandom_range(0, 9))
         0: return csa1_pkg::counter_type'($urandom);
         1: return gen_count - 16'h7FFF;
         2: return gen_count + csa1_pkg::HALF_RANGE;
         default: return csa1_pkg::counter_type'(int'(gen_count) + $urandom_range(0, 12) - 3);
      endcase
   endfunction

   task automatic queue_req(input logic [csa1_pkg::OPCODE_W-1:0] op,
                            input csa1_pkg::map_type m,
                            input csa1_pkg::counter_type inst);
      hop_req_type it;
      it.op = op;
      it.new_map = m;
      it.instant = inst;
      pending_reqs.push_back(it);
      if (op == csa1_pkg::OP_START) gen_count = '0;
      if (op == csa1_pkg::OP_EVENT) gen_count = gen_count + 16'd1;
      reqs_made++;
   endtask

   task automatic write_csr(input csa1_pkg::csr_index_type idx,
                            input logic [csa1_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Let every queued request go out and every report come back and the hopper go
   // idle, then give a trailing item extra time before the registers may change.
   task automatic drain_and_pause();
      while (pending_reqs.size() != 0 || req_bus.valid || channels_due.size() != 0 ||
             !req_bus.ready)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_hop(input logic [csa1_pkg::HOP_W-1:0] hop);
      logic [63:0] junk;
      logic [csa1_pkg::CSR_DATA_W-1:0] data;
      // Bits above the hop field carry noise; the register keeps only its low five.
      junk = {$urandom, $urandom};
      data = junk[csa1_pkg::CSR_DATA_W-1:0];
      data[csa1_pkg::HOP_W-1:0] = hop;
      write_csr(csa1_pkg::CSR_HOP_INCREMENT, data);
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: one item per transfer, with a random gap ahead of each.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (req_fire) req_gap = draw_wait(req_calm);
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() != 0) begin
            nxt = pending_reqs.pop_front();
            req_bus.opcode <= nxt.op;
            req_bus.new_map <= nxt.new_map;
            req_bus.instant <= nxt.instant;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: after each transfer the sink stalls for a random time.
   always @(negedge clock) begin
      if (rsp_fire) rsp_stall = draw_wait(rsp_calm);
      if (reset || rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         if (rsp_stall > 0) rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: tracks register writes, predicts on each accepted request and checks
   // each response transfer against the oldest channel report owed.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      req_take = !reset && req_bus.valid && req_bus.ready;
      rsp_take = !reset && rsp_bus.valid && rsp_bus.ready;

      if (!reset && csr_write_enable) begin
         case (csr_index)
            csa1_pkg::CSR_HOP_INCREMENT: cfg_hop = csr_write_data[csa1_pkg::HOP_W-1:0];
            csa1_pkg::CSR_INITIAL_MAP:   cfg_map = csr_write_data;
            default: begin
            end
         endcase
      end

      if (rsp_take) begin
         if (channels_due.size() == 0) begin
            $display("%0t: response with no event owed: channel %0d counter %0d", $time,
                     rsp_bus.channel, rsp_bus.event_counter);
            mismatches++;
         end else begin
            want = channels_due.pop_front();
            if (rsp_bus.channel !== want.channel) begin
               $display("%0t: channel expected %0d actual %0d", $time, want.channel,
                        rsp_bus.channel);
               mismatches++;
            end
            if (rsp_bus.rf_offset_mhz !== want.rf_offset) begin
               $display("%0t: rf_offset_mhz expected %0d actual %0d", $time,
                        want.rf_offset, rsp_bus.rf_offset_mhz);
               mismatches++;
            end
            if (rsp_bus.event_counter !== want.counter) begin
               $display("%0t: event_counter expected %0d actual %0d", $time, want.counter,
                        rsp_bus.event_counter);
               mismatches++;
            end
            if (rsp_bus.map_switched !== want.switched) begin
               $display("%0t: map_switched expected %0b actual %0b", $time, want.switched,
                        rsp_bus.map_switched);
               mismatches++;
            end
         end
      end

      if (req_take) step_hopper(req_bus.opcode, req_bus.new_map, req_bus.instant);

      req_fire <= req_take;
      rsp_fire <= rsp_take;

      if (req_take || rsp_take || csr_write_enable) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.new_map = '0;
      req_bus.instant = '0;
      rsp_bus.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;

      // Predictor state after reset; the registers come up with their defaults.
      cfg_hop = csa1_pkg::HOP_RESET;
      cfg_map = '1;
      unmapped = 0;
      evt_count = '0;
      active_map = '0;
      for (int c = 0; c < csa1_pkg::NUM_DATA_CHANNELS; c++) used_tab[c] = '0;
      used_cnt = 0;
      upd_pending = 1'b0;
      pend_map = '0;
      pend_inst = '0;
      gen_count = '0;
      reqs_made = 0;
      mismatches = 0;
      idle_cycles = 0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      req_gap = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Events before any start run on the empty reset map, so each unmapped channel
      // is used directly. A pending update is adopted even without a start, and a
      // reserved opcode must leave no trace.
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(OP_RESERVED, '1, 16'hFFFF);
      queue_req(csa1_pkg::OP_UPDATE, 37'h10_0000_0001, 16'd1);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_START, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      drain_and_pause();

      // Largest hop with only the top channel in the map: every unused channel remaps
      // to channel 36. Then an empty new map is dropped at its instant, an update
      // just outside the window is replaced by one at the far edge of the past.
      write_hop(5'd31);
      write_csr(csa1_pkg::CSR_INITIAL_MAP, 37'h10_0000_0000);
      queue_req(csa1_pkg::OP_START, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_UPDATE, '0, gen_count);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_UPDATE, '1, gen_count + 16'h7FFF);
      queue_req(csa1_pkg::OP_UPDATE, 37'h0A_AAAA_AAAA, gen_count - 16'h7FFF);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      drain_and_pause();

      // Zero hop on an empty map, then a one-channel map one event ahead: the first
      // event before the instant keeps the old map, the next one switches.
      write_hop(5'd0);
      write_csr(csa1_pkg::CSR_INITIAL_MAP, '0);
      queue_req(csa1_pkg::OP_START, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_UPDATE, 37'h2, gen_count + 16'd1);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      queue_req(csa1_pkg::OP_EVENT, '0, '0);
      drain_and_pause();

      // Random phases: each one sets the registers, starts a connection and runs
      // mostly events, with map updates, restarts and reserved opcodes mixed in.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: write_hop(5'd31);
            1: write_hop(5'd0);
            2: write_hop(5'd1);
            default: write_hop(csa1_pkg::HOP_W'($urandom_range(0, 31)));
         endcase
         case (ph)
            0: write_csr(csa1_pkg::CSR_INITIAL_MAP, '1);
            1: write_csr(csa1_pkg::CSR_INITIAL_MAP, '0);
            2: write_csr(csa1_pkg::CSR_INITIAL_MAP, 37'h10_0000_0000);
            3: write_csr(csa1_pkg::CSR_INITIAL_MAP, 37'h1);
            default: write_csr(csa1_pkg::CSR_INITIAL_MAP, rand_map());
         endcase
         queue_req(csa1_pkg::OP_START, '0, '0);
         reqs_made = 0;
         while (reqs_made < ITEMS_PER_PHASE) begin
            case ($urandom_range(0, 99)) inside
               [0:71]:  queue_req(csa1_pkg::OP_EVENT, rand_map(),
                                  csa1_pkg::counter_type'($urandom));
               [72:85]: queue_req(csa1_pkg::OP_UPDATE, rand_map(), pick_instant());
               [86:90]: queue_req(csa1_pkg::OP_START, rand_map(),
                                  csa1_pkg::counter_type'($urandom));
               default: queue_req(OP_RESERVED, rand_map(), csa1_pkg::counter_type'($urandom));
            endcase
         end
         drain_and_pause();
      end

      if (mismatches == 0 && channels_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
